// ===== sv/tgla_pkg.sv =====
// Types, constants and arithmetic helpers for the text glyph layout block.
// Used by the channel interfaces and by the front, queue, back and top modules.
`timescale 1ns / 1ps
`default_nettype none
package tgla_pkg;

  localparam int FRAC_BITS = 4;
  localparam int COORD_W   = 20;
  localparam int DELTA_W   = 22;
  localparam int WIDE_W    = 23;
  localparam int CHAR_W    = 16;
  localparam int METRIC_W  = 16;
  localparam int GLYPH_W   = 16;
  localparam int GH_W      = 16;
  localparam int ALIGN_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);

  localparam logic [ALIGN_W-1:0] H_LEFT   = 2'd0;
  localparam logic [ALIGN_W-1:0] H_CENTRE = 2'd1;
  localparam logic [ALIGN_W-1:0] H_RIGHT  = 2'd2;
  localparam logic [ALIGN_W-1:0] V_TOP    = 2'd0;
  localparam logic [ALIGN_W-1:0] V_MIDDLE = 2'd1;
  localparam logic [ALIGN_W-1:0] V_BOTTOM = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_ALIGN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_ALIGN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MULTILINE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd7;

  localparam logic [GH_W-1:0] GH_RESET = GH_W'(256);

  localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [COORD_W-1:0] COORD_MIN = COORD_W'(1 << (COORD_W - 1));
  localparam logic signed [WIDE_W-1:0]  WIDE_MAX  = WIDE_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0]  WIDE_MIN  = -WIDE_W'(1 << (COORD_W - 1));
  localparam logic signed [DELTA_W-1:0] ONE_PX    = DELTA_W'(1 << FRAC_BITS);
  localparam logic signed [DELTA_W-1:0] HALF_PX   = DELTA_W'(1 << FRAC_BITS) >>> 1;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_LINE,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic [GLYPH_W-1:0]          glyph;
    logic signed [DELTA_W-1:0]   dx;
    logic signed [DELTA_W-1:0]   dy;
    logic                        drop;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [GLYPH_W-1:0]        glyph;
  } entry_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [ALIGN_W-1:0]        h_align;
    logic [ALIGN_W-1:0]        v_align;
    logic                      multiline;
    logic [GH_W-1:0]           glyph_height;
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MAIN,
    FR_FIN
  } fr_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LRD,
    B_LWR,
    B_ERD,
    B_ELD
  } bk_state_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = COORD_MAX;
    end else if (v < WIDE_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // sel 1: half width, sel 2: full width, both rounded half up to whole pixels
  function automatic logic signed [DELTA_W-1:0] round_delta(
    input logic signed [DELTA_W-1:0] w,
    input logic [ALIGN_W-1:0]        sel
  );
    logic signed [DELTA_W-1:0] t;
    logic signed [DELTA_W-1:0] r;
    t = '0;
    r = '0;
    unique case (sel)
      H_CENTRE: begin
        t = w + ONE_PX;
        r = (t >>> (FRAC_BITS + 1)) <<< FRAC_BITS;
      end
      H_RIGHT: begin
        t = w + HALF_PX;
        r = (t >>> FRAC_BITS) <<< FRAC_BITS;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tgla_if.sv =====
// Channel interfaces: character input, placement output, register writes.
// Depends on tgla_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface tgla_in_if;
  import tgla_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CHAR_W-1:0]          char_code;
  logic                       glyph_found;
  logic signed [METRIC_W-1:0] glyph_bearing;
  logic [METRIC_W-1:0]        glyph_advance;
  logic [GLYPH_W-1:0]         glyph_number;
  logic                       last_char;
  modport source (output valid, char_code, glyph_found, glyph_bearing, glyph_advance,
                  glyph_number, last_char, input ready);
  modport sink (input valid, char_code, glyph_found, glyph_bearing, glyph_advance,
                glyph_number, last_char, output ready);
endinterface

interface tgla_out_if;
  import tgla_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] place_x;
  logic signed [COORD_W-1:0] place_y;
  logic [GLYPH_W-1:0]        glyph_out;
  logic                      end_of_run;
  logic                      overflowed;
  modport source (output valid, place_x, place_y, glyph_out, end_of_run, overflowed,
                  input ready);
  modport sink (input valid, place_x, place_y, glyph_out, end_of_run, overflowed,
                output ready);
endinterface

interface tgla_cfg_if;
  import tgla_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/tgla_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tgla_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/tgla_queue.sv =====
// Short command queue between the front and back parts.
// Depends on tgla_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps
`default_nettype none
module tgla_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tgla_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output tgla_pkg::cmd_t      head,
  output tgla_pkg::q_stat_t   stat
);
  import tgla_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = slot_r[rp_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

// ===== sv/tgla_front.sv =====
// Front part: accepts characters, tracks the pen and classifies each item
// into store, line-break and finish commands. Depends on tgla_pkg, tgla_if.
`timescale 1ns / 1ps
`default_nettype none
module tgla_front #(
  parameter int MAX_GLYPHS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tgla_in_if.sink                in_ch,
  input  wire tgla_pkg::cfg_t    cfg,
  input  wire tgla_pkg::q_stat_t q_stat,
  output logic                   push,
  output tgla_pkg::cmd_t         push_cmd
);
  import tgla_pkg::*;

  localparam int CNT_W = $clog2(MAX_GLYPHS + 1);

  fr_state_t st_r, st_nxt;

  logic [CHAR_W-1:0]          code_r;
  logic                       found_r;
  logic signed [METRIC_W-1:0] bearing_r;
  logic [METRIC_W-1:0]        advance_r;
  logic [GLYPH_W-1:0]         gnum_r;
  logic                       last_r;

  logic                      open_r, open_nxt;
  logic signed [COORD_W-1:0] pen_x_r, pen_x_nxt;
  logic signed [COORD_W-1:0] pen_y_r, pen_y_nxt;
  logic signed [COORD_W-1:0] anc_x_r, anc_x_nxt;
  logic signed [COORD_W-1:0] anc_y_r, anc_y_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      drop_r, drop_nxt;

  logic                      accept;
  logic                      is_nl;
  logic                      room;
  logic                      need_push;
  logic signed [WIDE_W-1:0]  sum_x;
  logic signed [WIDE_W-1:0]  sum_y;
  logic signed [WIDE_W-1:0]  adv_x;
  logic signed [WIDE_W-1:0]  down_y;
  logic signed [DELTA_W-1:0] line_w;
  logic signed [DELTA_W-1:0] block_h;

  assign accept    = in_ch.valid && in_ch.ready;
  assign is_nl     = cfg.multiline && (code_r == NEWLINE_CODE);
  assign room      = (cnt_r < CNT_W'(MAX_GLYPHS));
  assign need_push = is_nl || (found_r && room);

  assign sum_x   = WIDE_W'(pen_x_r) + WIDE_W'(bearing_r) + WIDE_W'(cfg.offset_x);
  assign sum_y   = WIDE_W'(pen_y_r) + WIDE_W'(cfg.offset_y);
  assign adv_x   = WIDE_W'(pen_x_r) + $signed({{(WIDE_W-METRIC_W){1'b0}}, advance_r});
  assign down_y  = WIDE_W'(pen_y_r) + $signed({{(WIDE_W-GH_W){1'b0}}, cfg.glyph_height});
  assign line_w  = DELTA_W'(pen_x_r) - DELTA_W'(anc_x_r);
  assign block_h = $signed({{(DELTA_W-GH_W){1'b0}}, cfg.glyph_height})
                   + DELTA_W'(pen_y_r) - DELTA_W'(anc_y_r);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FR_IDLE: begin
        if (accept) begin
          st_nxt = FR_MAIN;
        end
      end
      FR_MAIN: begin
        if (!(need_push && q_stat.full)) begin
          st_nxt = last_r ? FR_FIN : FR_IDLE;
        end
      end
      FR_FIN: begin
        if (!q_stat.full) begin
          st_nxt = FR_IDLE;
        end
      end
      default: begin
        st_nxt = FR_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready    = (st_r == FR_IDLE);
    push           = 1'b0;
    push_cmd       = '0;
    push_cmd.kind  = CMD_STORE;
    open_nxt       = open_r;
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    anc_x_nxt      = anc_x_r;
    anc_y_nxt      = anc_y_r;
    cnt_nxt        = cnt_r;
    drop_nxt       = drop_r;
    unique case (st_r)
      FR_IDLE: begin
        if (accept && !open_r) begin
          open_nxt  = 1'b1;
          anc_x_nxt = cfg.origin_x;
          anc_y_nxt = cfg.origin_y;
          pen_x_nxt = cfg.origin_x;
          pen_y_nxt = cfg.origin_y;
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
        end
      end
      FR_MAIN: begin
        if (!(need_push && q_stat.full)) begin
          if (is_nl) begin
            push          = 1'b1;
            push_cmd.kind = CMD_LINE;
            push_cmd.dx   = round_delta(line_w, cfg.h_align);
            pen_x_nxt     = anc_x_r;
            pen_y_nxt     = sat_coord(down_y);
          end else if (found_r) begin
            if (room) begin
              push           = 1'b1;
              push_cmd.kind  = CMD_STORE;
              push_cmd.x     = sat_coord(sum_x);
              push_cmd.y     = sat_coord(sum_y);
              push_cmd.glyph = gnum_r;
              cnt_nxt        = cnt_r + CNT_W'(1);
            end else begin
              drop_nxt = 1'b1;
            end
            pen_x_nxt = sat_coord(adv_x);
          end
        end
      end
      FR_FIN: begin
        if (!q_stat.full) begin
          push          = 1'b1;
          push_cmd.kind = CMD_FINISH;
          push_cmd.dx   = round_delta(line_w, cfg.h_align);
          push_cmd.dy   = round_delta(block_h, cfg.v_align);
          push_cmd.drop = drop_r;
          open_nxt      = 1'b0;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= FR_IDLE;
      open_r  <= 1'b0;
      pen_x_r <= '0;
      pen_y_r <= '0;
      anc_x_r <= '0;
      anc_y_r <= '0;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      open_r  <= open_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      anc_x_r <= anc_x_nxt;
      anc_y_r <= anc_y_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
    if (accept) begin
      code_r    <= in_ch.char_code;
      found_r   <= in_ch.glyph_found;
      bearing_r <= in_ch.glyph_bearing;
      advance_r <= in_ch.glyph_advance;
      gnum_r    <= in_ch.glyph_number;
      last_r    <= in_ch.last_char;
    end
  end
endmodule
`default_nettype wire

// ===== sv/tgla_back.sv =====
// Back part: stores placements, walks the buffer for line alignment and
// emits the aligned block. Depends on tgla_pkg, tgla_if and tgla_ram.
`timescale 1ns / 1ps
`default_nettype none
module tgla_back #(
  parameter int MAX_GLYPHS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tgla_pkg::cmd_t    head,
  input  wire tgla_pkg::q_stat_t q_stat,
  output logic                   pop,
  tgla_out_if.source             out_ch
);
  import tgla_pkg::*;

  localparam int CNT_W = $clog2(MAX_GLYPHS + 1);
  localparam int AW    = $clog2(MAX_GLYPHS);
  localparam int EW    = $bits(entry_t);

  bk_state_t st_r, st_nxt;

  logic [CNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [CNT_W-1:0] ls_r, ls_nxt;
  logic [AW-1:0]    k_r, k_nxt;

  logic signed [DELTA_W-1:0] dx_r;
  logic signed [DELTA_W-1:0] dy_r;
  logic                      drop_r;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  entry_t                    ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [EW-1:0]             ram_rdata;
  entry_t                    rd;
  logic                      slot_free;
  logic                      load_out;
  logic                      last_entry;
  logic                      line_done;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic signed [COORD_W-1:0] out_y_r;
  logic [GLYPH_W-1:0]        out_g_r;
  logic                      out_end_r;
  logic                      out_ovf_r;

  assign rd         = entry_t'(ram_rdata);
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign last_entry = (CNT_W'(k_r) + CNT_W'(1)) == wcnt_r;
  assign line_done  = (ls_r + CNT_W'(1)) == wcnt_r;

  tgla_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_GLYPHS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          unique case (head.kind)
            CMD_LINE:   st_nxt = (ls_r < wcnt_r) ? B_LRD : B_IDLE;
            CMD_FINISH: st_nxt = (wcnt_r != '0) ? B_ERD : B_IDLE;
            default:    st_nxt = B_IDLE;
          endcase
        end
      end
      B_LRD: st_nxt = B_LWR;
      B_LWR: st_nxt = line_done ? B_IDLE : B_LRD;
      B_ERD: st_nxt = B_ELD;
      B_ELD: begin
        if (slot_free) begin
          st_nxt = last_entry ? B_IDLE : B_ERD;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wcnt_r[AW-1:0];
    ram_wdata = entry_t'({head.x, head.y, head.glyph});
    ram_raddr = k_r;
    load_out  = 1'b0;
    wcnt_nxt  = wcnt_r;
    ls_nxt    = ls_r;
    k_nxt     = k_r;
    unique case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          unique case (head.kind)
            CMD_STORE: begin
              ram_we   = 1'b1;
              wcnt_nxt = wcnt_r + CNT_W'(1);
            end
            CMD_FINISH: begin
              k_nxt = '0;
            end
            default: begin
              k_nxt = k_r;
            end
          endcase
        end
      end
      B_LRD: begin
        ram_raddr = ls_r[AW-1:0];
      end
      B_LWR: begin
        ram_raddr = ls_r[AW-1:0];
        ram_we    = 1'b1;
        ram_waddr = ls_r[AW-1:0];
        ram_wdata = entry_t'({sat_coord(WIDE_W'(rd.x) - WIDE_W'(dx_r)), rd.y, rd.glyph});
        ls_nxt    = ls_r + CNT_W'(1);
      end
      B_ERD: begin
        ram_raddr = k_r;
      end
      B_ELD: begin
        ram_raddr = k_r;
        if (slot_free) begin
          load_out = 1'b1;
          if (last_entry) begin
            wcnt_nxt = '0;
            ls_nxt   = '0;
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      wcnt_r      <= '0;
      ls_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wcnt_r <= wcnt_nxt;
      ls_r   <= ls_nxt;
      k_r    <= k_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pop) begin
      dx_r   <= head.dx;
      dy_r   <= head.dy;
      drop_r <= head.drop;
    end
    if (load_out) begin
      out_x_r   <= (CNT_W'(k_r) >= ls_r) ? sat_coord(WIDE_W'(rd.x) - WIDE_W'(dx_r)) : rd.x;
      out_y_r   <= sat_coord(WIDE_W'(rd.y) - WIDE_W'(dy_r));
      out_g_r   <= rd.glyph;
      out_end_r <= last_entry;
      out_ovf_r <= drop_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.place_x    = out_x_r;
  assign out_ch.place_y    = out_y_r;
  assign out_ch.glyph_out  = out_g_r;
  assign out_ch.end_of_run = out_end_r;
  assign out_ch.overflowed = out_ovf_r;
endmodule
`default_nettype wire

// ===== sv/text_glyph_layout_align_top.sv =====
// Top level of the text glyph layout block: register file, front part,
// command queue and back part. Depends on tgla_pkg, tgla_if and the submodules.
//
//   port     dir   moves                        transfer when
//   in_ch    sink  one character + metrics      valid && ready
//   out_ch   src   one glyph placement          valid && ready
//   cfg_ch   sink  register index + data        valid && ready (ready always high)
//
// The front part takes a new character only when idle, after it has handled the last
// one and, at a string's end, queued the finish; the back part stores each glyph as
// it pops it. A line break reads and rewrites each glyph of the line in the placement
// RAM; the end of a string reads each placement and loads it out, held by stalls.
// Synchronous reset clears control state; the placement RAM needs no clearing pass.
// A full command queue stalls the front; a stalled output holds the back.
`timescale 1ns / 1ps
`default_nettype none
module text_glyph_layout_align_top #(
  parameter int MAX_GLYPHS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tgla_in_if.sink   in_ch,
  tgla_out_if.source out_ch,
  tgla_cfg_if.sink  cfg_ch
);
  import tgla_pkg::*;

  cfg_t    cfg_r;
  cfg_t    cfg_nxt;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head;
  q_stat_t q_stat;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_ch.data[COORD_W-1:0];
        REG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_ch.data[COORD_W-1:0];
        REG_H_ALIGN:      cfg_nxt.h_align      = cfg_ch.data[ALIGN_W-1:0];
        REG_V_ALIGN:      cfg_nxt.v_align      = cfg_ch.data[ALIGN_W-1:0];
        REG_MULTILINE:    cfg_nxt.multiline    = cfg_ch.data[0];
        REG_GLYPH_HEIGHT: cfg_nxt.glyph_height = cfg_ch.data[GH_W-1:0];
        REG_OFFSET_X:     cfg_nxt.offset_x     = cfg_ch.data[COORD_W-1:0];
        REG_OFFSET_Y:     cfg_nxt.offset_y     = cfg_ch.data[COORD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{origin_x: '0, origin_y: '0, h_align: H_LEFT, v_align: V_TOP,
                 multiline: 1'b0, glyph_height: GH_RESET, offset_x: '0, offset_y: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tgla_front #(
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tgla_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  tgla_back #(
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule
`default_nettype wire
